@@ hdl/tdc_pkg.sv @@
package tdc_pkg;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_POS1 = 2'd1,
		PH_POS2 = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		FN_TICK   = 2'd0,
		FN_TARGET = 2'd1,
		FN_SAMPLE = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_START   = 2'd1,
		EV_END     = 2'd2,
		EV_TIMEOUT = 2'd3
	} event_t;

	localparam logic [1:0] MT_SERVO = 2'd0;
	localparam logic [1:0] MT_COIL  = 2'd1;
	localparam logic [1:0] MT_BEMF  = 2'd2;

	localparam logic [1:0] TGT_POS1 = 2'd1;
	localparam logic [1:0] TGT_POS2 = 2'd2;

	localparam logic [2:0] REG_MOTOR_TYPE      = 3'd0;
	localparam logic [2:0] REG_ANGLE_MIN       = 3'd1;
	localparam logic [2:0] REG_ANGLE_MAX       = 3'd2;
	localparam logic [2:0] REG_MOVE_LIMIT_MS   = 3'd3;
	localparam logic [2:0] REG_SERVO_STEP_MS   = 3'd4;
	localparam logic [2:0] REG_COIL_ON_MS      = 3'd5;
	localparam logic [2:0] REG_COIL_OFF_MS     = 3'd6;
	localparam logic [2:0] REG_STALL_THRESHOLD = 3'd7;

	localparam int ADDR_W = 5;

	localparam logic [7:0] FULL_PWM = 8'd255;

	typedef struct packed {
		logic [1:0]  motor_type;
		logic [7:0]  angle_min;
		logic [7:0]  angle_max;
		logic [15:0] move_limit_ms;
		logic [9:0]  servo_step_ms;
		logic [9:0]  coil_on_ms;
		logic [9:0]  coil_off_ms;
		logic [11:0] stall_threshold;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] time_ms;
		logic        end1_sensed;
		logic        end2_sensed;
		logic [1:0]  target_request;
		logic [11:0] bemf_sample;
		logic        shared_motor_busy;
	} item_t;

	typedef struct packed {
		logic [1:0] move_phase;
		logic [7:0] servo_angle;
		logic       coil1_drive;
		logic       coil2_drive;
		logic [7:0] motor_pwm;
		logic       motor_forward;
		logic [1:0] move_event;
		logic       bemf_owned;
	} res_t;

endpackage

@@ hdl/tdc_if.sv @@
interface tdc_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] time_ms;
	logic        end1_sensed;
	logic        end2_sensed;
	logic [1:0]  target_request;
	logic [11:0] bemf_sample;
	logic        shared_motor_busy;

	modport source (
		output valid, func, time_ms, end1_sensed, end2_sensed,
			target_request, bemf_sample, shared_motor_busy,
		input  ready
	);
	modport sink (
		input  valid, func, time_ms, end1_sensed, end2_sensed,
			target_request, bemf_sample, shared_motor_busy,
		output ready
	);
endinterface

interface tdc_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] move_phase;
	logic [7:0] servo_angle;
	logic       coil1_drive;
	logic       coil2_drive;
	logic [7:0] motor_pwm;
	logic       motor_forward;
	logic [1:0] move_event;
	logic       bemf_owned;

	modport source (
		output valid, move_phase, servo_angle, coil1_drive, coil2_drive,
			motor_pwm, motor_forward, move_event, bemf_owned,
		input  ready
	);
	modport sink (
		input  valid, move_phase, servo_angle, coil1_drive, coil2_drive,
			motor_pwm, motor_forward, move_event, bemf_owned,
		output ready
	);
endinterface

@@ hdl/tdc_regs.sv @@
module tdc_regs
	import tdc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.motor_type      <= MT_SERVO;
			cfg_q.angle_min       <= 8'd0;
			cfg_q.angle_max       <= 8'd180;
			cfg_q.move_limit_ms   <= 16'd5000;
			cfg_q.servo_step_ms   <= 10'd20;
			cfg_q.coil_on_ms      <= 10'd50;
			cfg_q.coil_off_ms     <= 10'd200;
			cfg_q.stall_threshold <= 12'd10;
		end else if (wr_en) begin
			case (idx)
				REG_MOTOR_TYPE:      cfg_q.motor_type      <= pwdata[1:0];
				REG_ANGLE_MIN:       cfg_q.angle_min       <= pwdata[7:0];
				REG_ANGLE_MAX:       cfg_q.angle_max       <= pwdata[7:0];
				REG_MOVE_LIMIT_MS:   cfg_q.move_limit_ms   <= pwdata[15:0];
				REG_SERVO_STEP_MS:   cfg_q.servo_step_ms   <= pwdata[9:0];
				REG_COIL_ON_MS:      cfg_q.coil_on_ms      <= pwdata[9:0];
				REG_COIL_OFF_MS:     cfg_q.coil_off_ms     <= pwdata[9:0];
				REG_STALL_THRESHOLD: cfg_q.stall_threshold <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MOTOR_TYPE:      prdata = {30'd0, cfg_q.motor_type};
			REG_ANGLE_MIN:       prdata = {24'd0, cfg_q.angle_min};
			REG_ANGLE_MAX:       prdata = {24'd0, cfg_q.angle_max};
			REG_MOVE_LIMIT_MS:   prdata = {16'd0, cfg_q.move_limit_ms};
			REG_SERVO_STEP_MS:   prdata = {22'd0, cfg_q.servo_step_ms};
			REG_COIL_ON_MS:      prdata = {22'd0, cfg_q.coil_on_ms};
			REG_COIL_OFF_MS:     prdata = {22'd0, cfg_q.coil_off_ms};
			REG_STALL_THRESHOLD: prdata = {20'd0, cfg_q.stall_threshold};
			default:             prdata = 32'd0;
		endcase
	end

endmodule

@@ hdl/tdc_engine.sv @@
module tdc_engine
	import tdc_pkg::*;
#(
	parameter int STALL_COUNT_LIMIT = 5
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  advance,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  result
);

	localparam logic [3:0] STALL_LIMIT = 4'(STALL_COUNT_LIMIT);

	phase_t      phase_q, phase_d;
	logic [1:0]  target_q, target_d;
	logic [31:0] start_q, start_d;
	logic [31:0] last_q, last_d;
	logic [7:0]  angle_q, angle_d;
	logic [1:0]  coil_q, coil_d;
	logic        pwm_q, pwm_d;
	logic        fwd_q, fwd_d;
	logic        stall_q, stall_d;
	logic        held_q, held_d;
	logic [3:0]  run_q, run_d;
	event_t      ev;

	logic        bemf;
	logic        s1, s2, seen;
	logic [31:0] since_start, since_step;
	logic [10:0] coil_period;
	logic [1:0]  coil_bit;
	logic [3:0]  run_inc;

	assign bemf        = (cfg.motor_type == MT_BEMF);
	assign s1          = item.end1_sensed && !bemf;
	assign s2          = item.end2_sensed && !bemf;
	assign seen        = (phase_q == PH_POS1) ? s1 : s2;
	assign since_start = item.time_ms - start_q;
	assign since_step  = item.time_ms - last_q;
	assign coil_period = {1'b0, cfg.coil_on_ms} + {1'b0, cfg.coil_off_ms};
	assign coil_bit    = (phase_q == PH_POS1) ? 2'b01 : 2'b10;
	assign run_inc     = (item.bemf_sample < cfg.stall_threshold) ? run_q + 4'd1 : 4'd0;

	always_comb begin
		phase_t end_pos;
		logic   go;
		phase_d  = phase_q;
		target_d = target_q;
		start_d  = start_q;
		last_d   = last_q;
		angle_d  = angle_q;
		coil_d   = coil_q;
		pwm_d    = pwm_q;
		fwd_d    = fwd_q;
		stall_d  = stall_q;
		held_d   = held_q;
		run_d    = run_q;
		ev       = EV_NONE;
		end_pos  = PH_POS1;
		go       = 1'b0;
		case (func_t'(item.func))
			FN_TICK: begin
				if (phase_q == PH_IDLE) begin
					if (target_q == TGT_POS1 && !s1) begin
						go      = 1'b1;
						end_pos = PH_POS1;
					end else if (target_q == TGT_POS2 && !s2) begin
						go      = 1'b1;
						end_pos = PH_POS2;
					end
					// a busy shared driver keeps a back-EMF move from starting
					if (go && !(bemf && item.shared_motor_busy)) begin
						phase_d = end_pos;
						start_d = item.time_ms;
						ev      = EV_START;
						if (bemf) begin
							held_d  = 1'b1;
							stall_d = 1'b0;
							pwm_d   = 1'b1;
							fwd_d   = (end_pos == PH_POS1);
						end
					end
				end else if ((!bemf && seen) || (bemf && stall_q)) begin
					coil_d  = 2'b00;
					pwm_d   = 1'b0;
					held_d  = 1'b0;
					phase_d = PH_IDLE;
					ev      = EV_END;
				end else if (since_start > {16'd0, cfg.move_limit_ms}) begin
					coil_d  = 2'b00;
					pwm_d   = 1'b0;
					held_d  = 1'b0;
					phase_d = PH_IDLE;
					ev      = EV_TIMEOUT;
				end else if (cfg.motor_type == MT_SERVO) begin
					if (since_step > {22'd0, cfg.servo_step_ms}) begin
						if (phase_q == PH_POS1) begin
							if (angle_q > cfg.angle_min)
								angle_d = angle_q - 8'd1;
						end else begin
							if (angle_q < cfg.angle_max)
								angle_d = angle_q + 8'd1;
						end
						last_d = item.time_ms;
					end
				end else if (cfg.motor_type == MT_COIL) begin
					// a fresh pulse restarts the period, so the off test sees zero
					if (since_step > {21'd0, coil_period}) begin
						coil_d = coil_q | coil_bit;
						last_d = item.time_ms;
					end else if (since_step > {22'd0, cfg.coil_on_ms}) begin
						coil_d = coil_q & ~coil_bit;
					end
				end
			end
			FN_TARGET: begin
				if (item.target_request == TGT_POS1 || item.target_request == TGT_POS2)
					target_d = item.target_request;
			end
			FN_SAMPLE: begin
				if (held_q) begin
					if (run_inc > STALL_LIMIT) begin
						stall_d = 1'b1;
						run_d   = 4'd0;
					end else begin
						run_d   = run_inc;
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		result.move_phase    = phase_d;
		result.servo_angle   = angle_d;
		result.coil1_drive   = coil_d[0];
		result.coil2_drive   = coil_d[1];
		result.motor_pwm     = pwm_d ? FULL_PWM : 8'd0;
		result.motor_forward = fwd_d;
		result.move_event    = ev;
		result.bemf_owned    = held_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			target_q <= 2'd0;
			start_q  <= 32'd0;
			last_q   <= 32'd0;
			angle_q  <= 8'd0;
			coil_q   <= 2'b00;
			pwm_q    <= 1'b0;
			fwd_q    <= 1'b0;
			stall_q  <= 1'b0;
			held_q   <= 1'b0;
			run_q    <= 4'd0;
		end else if (advance) begin
			phase_q  <= phase_d;
			target_q <= target_d;
			start_q  <= start_d;
			last_q   <= last_d;
			angle_q  <= angle_d;
			coil_q   <= coil_d;
			pwm_q    <= pwm_d;
			fwd_q    <= fwd_d;
			stall_q  <= stall_d;
			held_q   <= held_d;
			run_q    <= run_d;
		end
	end

	a_held_moving: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> phase_q != PH_IDLE)
		else $error("motor driver held while idle");

	a_pwm_tracks_held: assert property (@(posedge clk) disable iff (!arst_n)
		pwm_q == held_q)
		else $error("PWM level out of step with driver ownership");

	a_run_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= STALL_LIMIT)
		else $error("low sample run passed the stall limit");

	a_start_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ev == EV_START |=> $past(phase_q) == PH_IDLE && phase_q != PH_IDLE)
		else $error("move start without leaving idle");

endmodule

@@ hdl/turnout_drive_controller.sv @@
// Channel | Dir  | Word
// cmd     | in   | func, time_ms, end1/2_sensed, target_request, bemf_sample, busy
// res     | out  | move_phase, servo_angle, coil1/2_drive, motor_pwm, motor_forward,
//         |      | move_event, bemf_owned
// apb     | in   | register writes and reads, 4-byte stride, pready always high
//
// One word per clock sustained while the result side is ready; a word passes the input
// register, then the result register, with the state updated as it enters the result
// register. Reset is asynchronous and returns the configuration registers, valid flags
// and state to their defaults. A stalled result holds the input register, which still
// takes a word while the result register drains.
module turnout_drive_controller
	import tdc_pkg::*;
#(
	parameter int STALL_COUNT_LIMIT = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	tdc_cmd_if.sink           cmd,
	tdc_res_if.source         res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res_s2;
	res_t  res_d;
	logic  valid_s2;
	logic  advance;

	tdc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tdc_engine #(
		.STALL_COUNT_LIMIT (STALL_COUNT_LIMIT)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (res_d)
	);

	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.ready)
				valid_s1 <= cmd.valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (res.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.func              <= cmd.func;
			item_s1.time_ms           <= cmd.time_ms;
			item_s1.end1_sensed       <= cmd.end1_sensed;
			item_s1.end2_sensed       <= cmd.end2_sensed;
			item_s1.target_request    <= cmd.target_request;
			item_s1.bemf_sample       <= cmd.bemf_sample;
			item_s1.shared_motor_busy <= cmd.shared_motor_busy;
		end
		if (advance)
			res_s2 <= res_d;
	end

	assign res.valid         = valid_s2;
	assign res.move_phase    = res_s2.move_phase;
	assign res.servo_angle   = res_s2.servo_angle;
	assign res.coil1_drive   = res_s2.coil1_drive;
	assign res.coil2_drive   = res_s2.coil2_drive;
	assign res.motor_pwm     = res_s2.motor_pwm;
	assign res.motor_forward = res_s2.motor_forward;
	assign res.move_event    = res_s2.move_event;
	assign res.bemf_owned    = res_s2.bemf_owned;

	a_start_shows_move: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.move_event == EV_START |-> res.move_phase != PH_IDLE)
		else $error("start event with idle phase");

	a_stop_shows_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.move_event == EV_END || res.move_event == EV_TIMEOUT)
		|-> res.move_phase == PH_IDLE && !res.bemf_owned && res.motor_pwm == 8'd0)
		else $error("stop event with drive still on");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res.ready |=> valid_s2 && $stable(res_s2))
		else $error("pending result overwritten");

endmodule

@@ tb/sv/tb_turnout_drive_controller.sv @@
`timescale 1ns / 100ps

module tb_turnout_drive_controller;
	import tdc_pkg::*;

	localparam int         STALL_LIMIT = 5;
	localparam int         QUIET_LIMIT = 400;
	localparam int         PHASES      = 16;
	localparam int         PHASE_WORDS = 83;
	localparam logic [1:0] MT_NONE     = 2'd3;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [31:0]       pwdata  = '0;
	logic [31:0]       prdata;
	logic              pready;

	tdc_cmd_if cmd_bus ();
	tdc_res_if res_bus ();

	item_t drv_item  = '0;
	logic  drv_valid = 1'b0;
	logic  mon_ready = 1'b0;

	assign cmd_bus.valid             = drv_valid;
	assign cmd_bus.func              = drv_item.func;
	assign cmd_bus.time_ms           = drv_item.time_ms;
	assign cmd_bus.end1_sensed       = drv_item.end1_sensed;
	assign cmd_bus.end2_sensed       = drv_item.end2_sensed;
	assign cmd_bus.target_request    = drv_item.target_request;
	assign cmd_bus.bemf_sample       = drv_item.bemf_sample;
	assign cmd_bus.shared_motor_busy = drv_item.shared_motor_busy;
	assign res_bus.ready             = mon_ready;

	turnout_drive_controller #(.STALL_COUNT_LIMIT(STALL_LIMIT)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_bus),
		.res     (res_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial forever #1 clk = ~clk;

	// register copy and switch state as the controller should hold them
	cfg_t cfg_now = '{motor_type: MT_SERVO, angle_min: 8'd0, angle_max: 8'd180,
		move_limit_ms: 16'd5000, servo_step_ms: 10'd20, coil_on_ms: 10'd50,
		coil_off_ms: 10'd200, stall_threshold: 12'd10};

	phase_t      ph_now    = PH_IDLE;
	logic [1:0]  tgt_now   = 2'd0;
	logic [31:0] start_ms  = '0;
	logic [31:0] step_ms   = '0;
	logic [7:0]  angle_now = '0;
	logic [1:0]  coil_now  = '0;
	logic        pwm_now   = 1'b0;
	logic        fwd_now   = 1'b0;
	logic        stall_now = 1'b0;
	logic        held_now  = 1'b0;
	logic [3:0]  low_run   = '0;

	item_t       pending_cmds[$];
	res_t        expected_drive[$];
	int          error_count  = 0;
	int          idle_pct     = 0;
	int          queued_total = 0;
	int          send_gap     = 0;
	int          ready_hold   = 0;
	int          quiet_cycles = 0;
	logic [31:0] now_ms       = 32'd1000;
	logic [1:0]  gen_target   = 2'd0;

	function automatic void halt_drive();
		coil_now = 2'b00;
		pwm_now  = 1'b0;
		held_now = 1'b0;
		ph_now   = PH_IDLE;
	endfunction

	function automatic event_t start_move(phase_t dest, logic [31:0] t, logic busy);
		if (cfg_now.motor_type == MT_BEMF && busy)
			return EV_NONE;
		ph_now   = dest;
		start_ms = t;
		if (cfg_now.motor_type == MT_BEMF) begin
			held_now  = 1'b1;
			stall_now = 1'b0;
			pwm_now   = 1'b1;
			fwd_now   = (dest == PH_POS1);
		end
		return EV_START;
	endfunction

	function automatic res_t turnout_step(item_t w);
		res_t        r;
		event_t      ev;
		logic        bemf, s1, s2, seen;
		logic [1:0]  cbit;
		logic [31:0] period;
		ev   = EV_NONE;
		bemf = (cfg_now.motor_type == MT_BEMF);
		case (w.func)
			FN_TICK: begin
				// back-EMF drive has no end sensors
				s1 = bemf ? 1'b0 : w.end1_sensed;
				s2 = bemf ? 1'b0 : w.end2_sensed;
				if (ph_now == PH_IDLE) begin
					if (tgt_now == TGT_POS1 && !s1)
						ev = start_move(PH_POS1, w.time_ms, w.shared_motor_busy);
					else if (tgt_now == TGT_POS2 && !s2)
						ev = start_move(PH_POS2, w.time_ms, w.shared_motor_busy);
				end else begin
					seen = (ph_now == PH_POS1) ? s1 : s2;
					if (bemf ? stall_now : seen) begin
						halt_drive();
						ev = EV_END;
					end else if ((w.time_ms - start_ms) > {16'd0, cfg_now.move_limit_ms}) begin
						halt_drive();
						ev = EV_TIMEOUT;
					end else if (cfg_now.motor_type == MT_SERVO) begin
						if ((w.time_ms - step_ms) > {22'd0, cfg_now.servo_step_ms}) begin
							if (ph_now == PH_POS1) begin
								if (angle_now > cfg_now.angle_min)
									angle_now = angle_now - 8'd1;
							end else if (angle_now < cfg_now.angle_max) begin
								angle_now = angle_now + 8'd1;
							end
							step_ms = w.time_ms;
						end
					end else if (cfg_now.motor_type == MT_COIL) begin
						cbit   = (ph_now == PH_POS1) ? 2'b01 : 2'b10;
						period = {22'd0, cfg_now.coil_on_ms} + {22'd0, cfg_now.coil_off_ms};
						if ((w.time_ms - step_ms) > period) begin
							coil_now = coil_now | cbit;
							step_ms  = w.time_ms;
						end
						if ((w.time_ms - step_ms) > {22'd0, cfg_now.coil_on_ms})
							coil_now = coil_now & ~cbit;
					end
				end
			end
			FN_TARGET: begin
				if (w.target_request == TGT_POS1 || w.target_request == TGT_POS2)
					tgt_now = w.target_request;
			end
			FN_SAMPLE: begin
				if (held_now) begin
					if (w.bemf_sample < cfg_now.stall_threshold)
						low_run = low_run + 4'd1;
					else
						low_run = 4'd0;
					if (low_run > STALL_LIMIT) begin
						stall_now = 1'b1;
						low_run   = 4'd0;
					end
				end
			end
			default: ;
		endcase
		r.move_phase    = ph_now;
		r.servo_angle   = angle_now;
		r.coil1_drive   = coil_now[0];
		r.coil2_drive   = coil_now[1];
		r.motor_pwm     = pwm_now ? FULL_PWM : 8'd0;
		r.motor_forward = fwd_now;
		r.move_event    = ev;
		r.bemf_owned    = held_now;
		return r;
	endfunction

	task automatic log_mismatch(string msg);
		error_count++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			log_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	// driver: one word per handshake, random send gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (drv_valid && cmd_bus.ready)
				expected_drive.push_back(turnout_step(drv_item));
			if (!drv_valid || cmd_bus.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					drv_valid <= 1'b0;
				end else if (pending_cmds.size() != 0 && idle_pct != 0 &&
						$urandom_range(0, 99) < idle_pct / 2) begin
					send_gap = $urandom_range(0, 8);
					drv_valid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					drv_item  <= pending_cmds.pop_front();
					drv_valid <= 1'b1;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result word with the oldest prediction
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n) begin
			if (res_bus.valid && mon_ready) begin
				got = '{res_bus.move_phase, res_bus.servo_angle, res_bus.coil1_drive,
					res_bus.coil2_drive, res_bus.motor_pwm, res_bus.motor_forward,
					res_bus.move_event, res_bus.bemf_owned};
				if (expected_drive.size() == 0) begin
					log_mismatch("result word with nothing expected");
				end else begin
					want = expected_drive.pop_front();
					check_field("move_phase", 8'(got.move_phase), 8'(want.move_phase));
					check_field("servo_angle", got.servo_angle, want.servo_angle);
					check_field("coil1_drive", 8'(got.coil1_drive), 8'(want.coil1_drive));
					check_field("coil2_drive", 8'(got.coil2_drive), 8'(want.coil2_drive));
					check_field("motor_pwm", got.motor_pwm, want.motor_pwm);
					check_field("motor_forward", 8'(got.motor_forward),
						8'(want.motor_forward));
					check_field("move_event", 8'(got.move_event), 8'(want.move_event));
					check_field("bemf_owned", 8'(got.bemf_owned), 8'(want.bemf_owned));
				end
			end
			if (ready_hold > 0) begin
				ready_hold--;
				mon_ready <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
				ready_hold = $urandom_range(0, 8);
				mon_ready <= 1'b0;
			end else begin
				mon_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_turnout_drive_controller: errors");
			$finish;
		end
	end

	task automatic queue_cmd(item_t w);
		pending_cmds.push_back(w);
		queued_total++;
	endtask

	function automatic item_t tick_word(logic [31:0] t, logic s1, logic s2, logic busy);
		item_t w;
		w.func              = FN_TICK;
		w.time_ms           = t;
		w.end1_sensed       = s1;
		w.end2_sensed       = s2;
		w.target_request    = 2'($urandom);
		w.bemf_sample       = 12'($urandom);
		w.shared_motor_busy = busy;
		return w;
	endfunction

	function automatic item_t target_word(logic [1:0] req);
		item_t w;
		w = tick_word($urandom, 1'($urandom), 1'($urandom), 1'($urandom));
		w.func           = FN_TARGET;
		w.target_request = req;
		return w;
	endfunction

	function automatic item_t sample_word(logic [11:0] v);
		item_t w;
		w = tick_word($urandom, 1'($urandom), 1'($urandom), 1'($urandom));
		w.func        = FN_SAMPLE;
		w.bemf_sample = v;
		return w;
	endfunction

	function automatic logic [11:0] pick_sample(logic low);
		if (low && cfg_now.stall_threshold != 0)
			return 12'($urandom_range(0, 32'(cfg_now.stall_threshold) - 1));
		return 12'($urandom_range(0, 4095));
	endfunction

	// short steps, steps up to and past the step or pulse scale, a few near or past the timeout
	function automatic logic [31:0] time_step();
		int unsigned span, r;
		case (cfg_now.motor_type)
			MT_SERVO: span = 32'(cfg_now.servo_step_ms) + 1;
			MT_COIL:  span = 32'(cfg_now.coil_on_ms) + 32'(cfg_now.coil_off_ms) + 1;
			default:  span = 20;
		endcase
		r = $urandom_range(0, 99);
		if (r < 35)
			return $urandom_range(0, 3);
		if (r < 75)
			return $urandom_range(0, span);
		if (r < 96)
			return $urandom_range(span, 2 * span + 1);
		if (r < 98)
			return 32'(cfg_now.move_limit_ms) + $urandom_range(0, 2);
		return $urandom;
	endfunction

	// one target command and ticks with samples that tend to reach the end sensor or stall, or at times one random word
	task automatic gen_move();
		item_t      w;
		int         n, k, i, j, lows;
		logic [1:0] req;
		logic       late, s_end, s_other;
		if ($urandom_range(0, 9) == 0) begin
			w.func              = 2'($urandom);
			w.time_ms           = ($urandom_range(0, 1) == 1) ? $urandom : now_ms;
			w.end1_sensed       = 1'($urandom);
			w.end2_sensed       = 1'($urandom);
			w.target_request    = 2'($urandom);
			w.bemf_sample       = 12'($urandom);
			w.shared_motor_busy = 1'($urandom);
			queue_cmd(w);
			return;
		end
		if ($urandom_range(0, 9) < 8)
			req = ($urandom_range(0, 1) == 1) ? TGT_POS2 : TGT_POS1;
		else
			req = ($urandom_range(0, 1) == 1) ? 2'd3 : 2'd0;
		if (req == TGT_POS1 || req == TGT_POS2)
			gen_target = req;
		queue_cmd(target_word(req));
		n = $urandom_range(2, 10);
		k = $urandom_range(1, n);
		for (i = 1; i <= n; i++) begin
			late    = (i >= k);
			now_ms  = now_ms + time_step();
			s_end   = late && ($urandom_range(0, 5) != 0);
			s_other = ($urandom_range(0, 9) == 0);
			queue_cmd(tick_word(now_ms, (gen_target == TGT_POS1) ? s_end : s_other,
				(gen_target == TGT_POS2) ? s_end : s_other, $urandom_range(0, 6) == 0));
			if (cfg_now.motor_type == MT_BEMF || $urandom_range(0, 9) == 0) begin
				lows = late ? $urandom_range(3, 8) : $urandom_range(0, 2);
				for (j = 0; j < lows; j++)
					queue_cmd(sample_word(pick_sample(late && $urandom_range(0, 9) != 0)));
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || drv_valid || expected_drive.size() != 0);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] value, int unsigned w);
		logic [31:0] junk;
		junk = ($urandom_range(0, 1) == 1) ? ($urandom << w) : 32'd0;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value | junk;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic load_setting(cfg_t s);
		reg_write(REG_MOTOR_TYPE, 32'(s.motor_type), 2);
		reg_write(REG_ANGLE_MIN, 32'(s.angle_min), 8);
		reg_write(REG_ANGLE_MAX, 32'(s.angle_max), 8);
		reg_write(REG_MOVE_LIMIT_MS, 32'(s.move_limit_ms), 16);
		reg_write(REG_SERVO_STEP_MS, 32'(s.servo_step_ms), 10);
		reg_write(REG_COIL_ON_MS, 32'(s.coil_on_ms), 10);
		reg_write(REG_COIL_OFF_MS, 32'(s.coil_off_ms), 10);
		reg_write(REG_STALL_THRESHOLD, 32'(s.stall_threshold), 12);
		@(negedge clk);
		cfg_now = s;
	endtask

	function automatic cfg_t random_cfg(logic [1:0] mt);
		cfg_t s;
		s.motor_type      = mt;
		s.angle_min       = 8'($urandom_range(0, 180));
		s.angle_max       = 8'($urandom_range(0, 180));
		s.move_limit_ms   = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 400)) :
			16'($urandom);
		s.servo_step_ms   = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 30)) :
			10'($urandom);
		s.coil_on_ms      = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 40)) :
			10'($urandom);
		s.coil_off_ms     = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 60)) :
			10'($urandom);
		s.stall_threshold = 12'($urandom);
		return s;
	endfunction

	initial begin
		cfg_t        s;
		int          p, base;
		int unsigned pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		idle_pct = 25;

		// reset settings: servo, 20 ms step, 5000 ms timeout
		queue_cmd(item_t'{FN_NOP, 32'hFFFF_FFFF, 1'b1, 1'b1, 2'd3, 12'hFFF, 1'b1});
		queue_cmd(sample_word(12'd0));
		queue_cmd(sample_word(12'hFFF));
		queue_cmd(tick_word(32'd0, 1'b0, 1'b0, 1'b0));
		queue_cmd(target_word(2'd0));
		queue_cmd(target_word(2'd3));
		queue_cmd(target_word(TGT_POS2));
		queue_cmd(tick_word(32'd100, 1'b0, 1'b1, 1'b1));
		queue_cmd(tick_word(32'd110, 1'b1, 1'b0, 1'b0));
		queue_cmd(tick_word(32'd131, 1'b1, 1'b0, 1'b0));
		queue_cmd(tick_word(32'd151, 1'b0, 1'b0, 1'b0));
		queue_cmd(tick_word(32'd152, 1'b0, 1'b0, 1'b0));
		queue_cmd(tick_word(32'd200, 1'b0, 1'b1, 1'b0));
		queue_cmd(target_word(TGT_POS1));
		queue_cmd(tick_word(32'd300, 1'b0, 1'b0, 1'b0));
		queue_cmd(tick_word(32'd330, 1'b0, 1'b1, 1'b0));
		queue_cmd(tick_word(32'd5300, 1'b0, 1'b0, 1'b0));
		queue_cmd(tick_word(32'd5301, 1'b0, 1'b0, 1'b0));
		queue_cmd(target_word(TGT_POS2));
		queue_cmd(tick_word(32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0));
		queue_cmd(tick_word(32'h0000_0010, 1'b0, 1'b0, 1'b0));
		queue_cmd(tick_word(32'h0000_1379, 1'b0, 1'b0, 1'b0));
		gen_target = TGT_POS2;
		wait_drained();

		for (p = 0; p < PHASES; p++) begin
			pick = $urandom_range(0, 9);
			s = random_cfg((pick < 3) ? MT_SERVO : (pick < 6) ? MT_COIL :
				(pick < 9) ? MT_BEMF : MT_NONE);
			case (p)
				0: begin
					s.motor_type    = MT_SERVO;
					s.angle_min     = 8'd0;
					s.angle_max     = 8'd180;
					s.move_limit_ms = 16'hFFFF;
					s.servo_step_ms = 10'd0;
				end
				1: begin
					s.motor_type    = MT_SERVO;
					s.angle_min     = 8'd180;
					s.angle_max     = 8'd0;
					s.move_limit_ms = 16'd0;
					s.servo_step_ms = 10'h3FF;
				end
				2: begin
					s.motor_type  = MT_COIL;
					s.coil_on_ms  = 10'd0;
					s.coil_off_ms = 10'd0;
				end
				3: begin
					s.motor_type    = MT_COIL;
					s.move_limit_ms = 16'hFFFF;
					s.coil_on_ms    = 10'h3FF;
					s.coil_off_ms   = 10'h3FF;
				end
				4: begin
					s.motor_type      = MT_BEMF;
					s.stall_threshold = 12'd0;
				end
				5: begin
					s.motor_type      = MT_BEMF;
					s.stall_threshold = 12'hFFF;
				end
				6: s.motor_type = MT_NONE;
				7: begin
					s.motor_type      = MT_BEMF;
					s.move_limit_ms   = 16'hFFFF;
					s.stall_threshold = 12'($urandom_range(200, 3000));
				end
				default: ;
			endcase
			load_setting(s);
			// no idling in some phases and none at the end of the run
			idle_pct = (p >= PHASES - 2 || p % 4 == 3) ? 0 : 25;
			base = queued_total;
			while (queued_total - base < PHASE_WORDS)
				gen_move();
			wait_drained();
		end

		repeat (8) @(negedge clk);
		if (error_count == 0)
			$display("tb_turnout_drive_controller: clean");
		else
			$display("tb_turnout_drive_controller: errors");
		$finish;
	end

endmodule

@@ files.f @@
hdl/tdc_pkg.sv
hdl/tdc_if.sv
hdl/tdc_regs.sv
hdl/tdc_engine.sv
hdl/turnout_drive_controller.sv
tb/sv/tb_turnout_drive_controller.sv
